@@ hdl/batch_norm_2d_forward_core_macros.svh @@
// assertion macros for the batch normalization core checker
// used by bn2d_chk, which sees only the top level ports
`ifndef BATCH_NORM_2D_FORWARD_CORE_MACROS_SVH
`define BATCH_NORM_2D_FORWARD_CORE_MACROS_SVH

// clocked assertion, off while reset is held
`define BN2D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// cause in one cycle, effect in the next
`define BN2D_ASSERT_NEXT(lbl, pre, post, msg) \
    `BN2D_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ hdl/bn2d_pkg.sv @@
// shared types, codes and saturation helpers for the batch normalization core
// no dependencies
package bn2d_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CHANNELS_DEF = 64;

    localparam logic [12:0]        COUNT_MAX = 13'd8191;
    localparam logic signed [31:0] I32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q     = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0]        RECIP_NUM = 64'd1 << (2 * FRAC_BITS);
    localparam logic [16:0]        MOM_ONE   = 17'h1_0000;
    localparam logic [16:0]        EPS_RST   = 17'd1;
    localparam logic [16:0]        MOM_RST   = 17'd6554;

    // request codes
    localparam logic [2:0] REQ_GAMMA = 3'd0;
    localparam logic [2:0] REQ_BETA  = 3'd1;
    localparam logic [2:0] REQ_MMEAN = 3'd2;
    localparam logic [2:0] REQ_MVAR  = 3'd3;
    localparam logic [2:0] REQ_MEAN  = 3'd4;
    localparam logic [2:0] REQ_VAR   = 3'd5;
    localparam logic [2:0] REQ_NORM  = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_NORM = 2'd0;
    localparam logic [1:0] KIND_MEAN = 2'd1;
    localparam logic [1:0] KIND_VAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TRAIN = 2'd0;
    localparam logic [1:0] CFG_EPS   = 2'd1;
    localparam logic [1:0] CFG_MOM   = 2'd2;

    typedef struct packed {
        logic signed [31:0] gamma;
        logic signed [31:0] beta;
        logic signed [31:0] mmean;
        logic signed [31:0] mvar;
        logic signed [31:0] minv;
    } t_entry;

    typedef enum logic {IU_DIV, IU_SQRT} t_iu_op;

    typedef struct packed {
        logic   start;
        t_iu_op op;
    } t_iu_ctl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_iu_sts;

    typedef enum logic {TGT_MOV, TGT_BATCH} t_tgt;

    typedef enum logic [4:0] {
        ST_SWP_RD, ST_SWP_EX, ST_IDLE, ST_EXEC, ST_SQR, ST_DV, ST_DVW,
        ST_IR_SQ, ST_IR_SQW, ST_IR_RC, ST_IR_RCW, ST_IR_END,
        ST_BL1, ST_BL2, ST_BL3, ST_N2, ST_N3, ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sh0000_0000_7FFF_FFFF) return I32_MAX;
        else if (a < -64'sh0000_0000_8000_0000) return I32_MIN;
        else return a[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (!s[64] && s[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (s[64] && !s[63]) return 64'sh8000_0000_0000_0000;
        else return s[63:0];
    endfunction

    function automatic logic signed [31:0] clamp0(input logic signed [31:0] a);
        return a[31] ? 32'sd0 : a;
    endfunction

endpackage

@@ hdl/batch_norm_2d_forward_core.sv @@
// one item at a time (parameter writes, mean/var samples, normalize requests); a normalize
// result goes to the output register; the last sample of a mean pass adds the 64-step divide,
// of a var pass also one inverse root (twice in training mode); a moving variance write runs one
// inverse root; an inverse root is a 32-step root plus, unless the root is zero, a 64-step divide
// in the shared iterative unit; after reset and after each epsilon write a sweep recomputes
// every channel entry, with input and configuration ready held low
module batch_norm_2d_forward_core #(
    parameter int CHANNELS = bn2d_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic [5:0]         i_channel,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_out_kind,
    output logic signed [31:0] o_out_value,
    output logic               o_out_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import bn2d_pkg::*;

    localparam int             AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0]  LAST_CH = AW'(CHANNELS - 1);

    t_state              r_state, n_state;
    logic                r_train, n_train;
    logic [16:0]         r_eps, n_eps;
    logic [16:0]         r_mom, n_mom;
    logic signed [63:0]  r_sum, n_sum;
    logic [12:0]         r_cnt, n_cnt;
    logic signed [31:0]  r_bmean, n_bmean;
    logic signed [31:0]  r_bvar, n_bvar;
    logic signed [31:0]  r_binv, n_binv;
    logic                r_init, n_init;
    logic                r_sweep, n_sweep;
    logic [AW-1:0]       r_addr, n_addr;
    logic [2:0]          r_req, n_req;
    logic signed [31:0]  r_x, n_x;
    logic                r_last, n_last;
    t_entry              r_ent, n_ent;
    logic [32:0]         r_s, n_s;
    logic [31:0]         r_root, n_root;
    logic signed [31:0]  r_inv, n_inv;
    t_tgt                r_tgt, n_tgt;
    logic [63:0]         r_prod, n_prod;
    logic signed [49:0]  r_p1, n_p1;
    logic signed [49:0]  r_p2, n_p2;
    logic                r_neg, n_neg;
    logic [1:0]          r_okind, n_okind;
    logic signed [31:0]  r_ores, n_ores;
    logic                r_olast, n_olast;
    logic                r_ovalid, n_ovalid;
    logic [1:0]          r_out_kind, n_out_kind;
    logic signed [31:0]  r_out_value, n_out_value;
    logic                r_out_last, n_out_last;

    t_entry              r_mem [CHANNELS];
    t_entry              r_rd;
    logic                mem_we;
    t_entry              mem_wd;
    logic [AW-1:0]       rd_addr;

    t_iu_ctl             iu_ctl;
    logic [63:0]         iu_a;
    logic [31:0]         iu_b;
    t_iu_sts             iu_sts;
    logic [63:0]         iu_res;

    logic [31:0]         ch_ext;
    logic [AW-1:0]       in_addr;
    logic                in_ok;
    logic                in_acc;
    logic                cfg_acc;
    logic [16:0]         mom_c;
    logic [16:0]         mom_n;
    logic signed [31:0]  mu;
    logic signed [31:0]  inv;
    logic signed [31:0]  dn;
    logic signed [31:0]  dv;
    logic [31:0]         ad;
    logic [63:0]         sq_sh;
    logic [12:0]         cnt_inc;
    logic signed [31:0]  nv;
    logic signed [50:0]  bl_t;
    logic signed [31:0]  bl_v;
    logic signed [31:0]  var_q;
    logic signed [31:0]  mean_q;

    bn2d_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iu_ctl),
        .i_a     (iu_a),
        .i_b     (iu_b),
        .o_sts   (iu_sts),
        .o_res   (iu_res)
    );

    assign ch_ext  = 32'(i_channel);
    assign in_addr = ch_ext[AW-1:0];
    assign in_ok   = (ch_ext < 32'(CHANNELS)) && (i_req_type <= REQ_NORM);
    assign in_acc  = i_in_valid && o_in_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign rd_addr = (r_state == ST_IDLE) ? in_addr : r_addr;

    assign mom_c   = (r_mom > MOM_ONE) ? MOM_ONE : r_mom;
    assign mom_n   = MOM_ONE - mom_c;
    assign mu      = r_train ? r_bmean : r_rd.mmean;
    assign inv     = r_train ? r_binv : r_rd.minv;
    assign dn      = sat32(64'(r_x) - 64'(mu));
    assign dv      = sat32(64'(r_x) - 64'(r_bmean));
    assign ad      = dv[31] ? (~dv + 32'd1) : dv;
    assign sq_sh   = r_prod >> FRAC_BITS;
    assign cnt_inc = (r_cnt < COUNT_MAX) ? r_cnt + 13'd1 : r_cnt;
    assign nv      = sat32($signed(r_prod) >>> FRAC_BITS);
    assign bl_t    = 51'(r_p1) + 51'(r_p2);
    assign bl_v    = sat32(64'(bl_t >>> 16));

    // quotient magnitude back to a signed word, truncated toward zero
    assign mean_q = r_neg ? ((iu_res > 64'h8000_0000) ? I32_MIN : -$signed(iu_res[31:0]))
                          : ((iu_res > 64'(I32_MAX)) ? I32_MAX : iu_res[31:0]);
    assign var_q  = r_neg ? 32'sd0 : ((iu_res > 64'(I32_MAX)) ? I32_MAX : iu_res[31:0]);

    always_comb begin
        n_state     = r_state;
        n_train     = r_train;
        n_eps       = r_eps;
        n_mom       = r_mom;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_bmean     = r_bmean;
        n_bvar      = r_bvar;
        n_binv      = r_binv;
        n_init      = r_init;
        n_sweep     = r_sweep;
        n_addr      = r_addr;
        n_req       = r_req;
        n_x         = r_x;
        n_last      = r_last;
        n_ent       = r_ent;
        n_s         = r_s;
        n_root      = r_root;
        n_inv       = r_inv;
        n_tgt       = r_tgt;
        n_prod      = r_prod;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_neg       = r_neg;
        n_okind     = r_okind;
        n_ores      = r_ores;
        n_olast     = r_olast;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_wd      = r_ent;
        iu_ctl      = '{start: 1'b0, op: IU_DIV};
        iu_a        = '0;
        iu_b        = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;

        unique case (r_state)
            ST_SWP_RD: n_state = ST_SWP_EX;
            ST_SWP_EX: begin
                if (r_init) begin
                    n_ent = '{gamma: ONE_Q, beta: '0, mmean: '0, mvar: '0, minv: '0};
                    n_s   = 33'(r_eps);
                end else begin
                    n_ent = r_rd;
                    n_s   = 33'(clamp0(r_rd.mvar)) + 33'(r_eps);
                end
                n_tgt   = TGT_MOV;
                n_state = ST_IR_SQ;
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cfg_ready = !i_in_valid;
                if (cfg_acc) begin
                    unique case (i_cfg_index)
                        CFG_TRAIN: n_train = i_cfg_data[0];
                        CFG_EPS: begin
                            n_eps   = i_cfg_data;
                            n_sweep = 1'b1;
                            n_addr  = '0;
                            n_state = ST_SWP_RD;
                        end
                        CFG_MOM: n_mom = i_cfg_data;
                        default: ;
                    endcase
                end else if (in_acc) begin
                    n_req  = i_req_type;
                    n_addr = in_addr;
                    n_x    = i_value;
                    n_last = i_last;
                    if (in_ok) n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_ent   = r_rd;
                n_state = ST_IDLE;
                unique case (r_req)
                    REQ_GAMMA: begin
                        mem_we       = 1'b1;
                        mem_wd       = r_rd;
                        mem_wd.gamma = r_x;
                    end
                    REQ_BETA: begin
                        mem_we      = 1'b1;
                        mem_wd      = r_rd;
                        mem_wd.beta = r_x;
                    end
                    REQ_MMEAN: begin
                        mem_we       = 1'b1;
                        mem_wd       = r_rd;
                        mem_wd.mmean = r_x;
                    end
                    REQ_MVAR: begin
                        n_ent.mvar = clamp0(r_x);
                        n_s        = 33'(clamp0(r_x)) + 33'(r_eps);
                        n_tgt      = TGT_MOV;
                        n_state    = ST_IR_SQ;
                    end
                    REQ_MEAN: begin
                        n_sum = sat_add64(r_sum, 64'(r_x));
                        n_cnt = cnt_inc;
                        if (r_last) n_state = ST_DV;
                    end
                    REQ_VAR: begin
                        n_prod  = 64'(ad) * 64'(ad);
                        n_state = ST_SQR;
                    end
                    REQ_NORM: begin
                        n_prod  = 64'(dn) * 64'(inv);
                        n_state = ST_N2;
                    end
                    default: ;
                endcase
            end
            ST_SQR: begin
                n_sum   = sat_add64(r_sum, $signed(sq_sh));
                n_cnt   = cnt_inc;
                n_state = r_last ? ST_DV : ST_IDLE;
            end
            ST_DV: begin
                iu_ctl  = '{start: 1'b1, op: IU_DIV};
                iu_a    = r_sum[63] ? (~r_sum + 64'd1) : r_sum;
                iu_b    = 32'(r_cnt);
                n_neg   = r_sum[63];
                n_sum   = '0;
                n_cnt   = '0;
                n_state = ST_DVW;
            end
            ST_DVW: begin
                if (iu_sts.done) begin
                    n_olast = 1'b0;
                    if (r_req == REQ_MEAN) begin
                        n_bmean = mean_q;
                        n_ores  = mean_q;
                        n_okind = KIND_MEAN;
                        n_state = ST_OUT;
                    end else begin
                        n_bvar  = var_q;
                        n_ores  = var_q;
                        n_okind = KIND_VAR;
                        n_s     = 33'(var_q) + 33'(r_eps);
                        n_tgt   = TGT_BATCH;
                        n_state = ST_IR_SQ;
                    end
                end
            end
            ST_IR_SQ: begin
                iu_ctl  = '{start: 1'b1, op: IU_SQRT};
                iu_a    = 64'(r_s) << FRAC_BITS;
                n_state = ST_IR_SQW;
            end
            ST_IR_SQW: begin
                if (iu_sts.done) begin
                    if (iu_sts.zero) begin
                        n_inv   = I32_MAX;
                        n_state = ST_IR_END;
                    end else begin
                        n_root  = iu_res[31:0];
                        n_state = ST_IR_RC;
                    end
                end
            end
            ST_IR_RC: begin
                iu_ctl  = '{start: 1'b1, op: IU_DIV};
                iu_a    = RECIP_NUM;
                iu_b    = r_root;
                n_state = ST_IR_RCW;
            end
            ST_IR_RCW: begin
                if (iu_sts.done) begin
                    n_inv   = (iu_res > 64'(I32_MAX)) ? I32_MAX : iu_res[31:0];
                    n_state = ST_IR_END;
                end
            end
            ST_IR_END: begin
                if (r_tgt == TGT_BATCH) begin
                    n_binv  = r_inv;
                    n_state = r_train ? ST_BL1 : ST_OUT;
                end else begin
                    mem_we      = 1'b1;
                    mem_wd      = r_ent;
                    mem_wd.minv = r_inv;
                    if (r_sweep) begin
                        if (r_addr == LAST_CH) begin
                            n_sweep = 1'b0;
                            n_init  = 1'b0;
                            n_state = ST_IDLE;
                        end else begin
                            n_addr  = r_addr + AW'(1);
                            n_state = ST_SWP_RD;
                        end
                    end else begin
                        n_state = (r_req == REQ_VAR) ? ST_OUT : ST_IDLE;
                    end
                end
            end
            // moving statistics blend, one multiplier pair per cycle
            ST_BL1: begin
                n_p1    = $signed({1'b0, mom_n}) * r_ent.mmean;
                n_p2    = $signed({1'b0, mom_c}) * r_bmean;
                n_state = ST_BL2;
            end
            ST_BL2: begin
                n_ent.mmean = bl_v;
                n_p1        = $signed({1'b0, mom_n}) * r_ent.mvar;
                n_p2        = $signed({1'b0, mom_c}) * r_bvar;
                n_state     = ST_BL3;
            end
            ST_BL3: begin
                n_ent.mvar = bl_v;
                n_s        = 33'(clamp0(bl_v)) + 33'(r_eps);
                n_tgt      = TGT_MOV;
                n_state    = ST_IR_SQ;
            end
            ST_N2: begin
                n_prod  = 64'(r_ent.gamma) * 64'(nv);
                n_state = ST_N3;
            end
            ST_N3: begin
                n_ores  = sat32(($signed(r_prod) >>> FRAC_BITS) + 64'(r_ent.beta));
                n_okind = KIND_NORM;
                n_olast = r_last;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid    = 1'b1;
                    n_out_kind  = r_okind;
                    n_out_value = r_ores;
                    n_out_last  = r_olast;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SWP_RD;
            r_init   <= 1'b1;
            r_sweep  <= 1'b1;
            r_addr   <= '0;
            r_train  <= 1'b0;
            r_eps    <= EPS_RST;
            r_mom    <= MOM_RST;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_bmean  <= '0;
            r_bvar   <= '0;
            r_binv   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_sweep  <= n_sweep;
            r_addr   <= n_addr;
            r_train  <= n_train;
            r_eps    <= n_eps;
            r_mom    <= n_mom;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_bmean  <= n_bmean;
            r_bvar   <= n_bvar;
            r_binv   <= n_binv;
            r_ovalid <= n_ovalid;
        end
        r_req       <= n_req;
        r_x         <= n_x;
        r_last      <= n_last;
        r_ent       <= n_ent;
        r_s         <= n_s;
        r_root      <= n_root;
        r_inv       <= n_inv;
        r_tgt       <= n_tgt;
        r_prod      <= n_prod;
        r_p1        <= n_p1;
        r_p2        <= n_p2;
        r_neg       <= n_neg;
        r_okind     <= n_okind;
        r_ores      <= n_ores;
        r_olast     <= n_olast;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

@@ hdl/bn2d_iter.sv @@
// shared iterative unit: 64/32 restoring divide (one bit a cycle)
// and 64-bit integer square root (one result bit a cycle); uses bn2d_pkg
module bn2d_iter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bn2d_pkg::t_iu_ctl i_ctl,
    input  logic [63:0]       i_a,
    input  logic [31:0]       i_b,
    output bn2d_pkg::t_iu_sts o_sts,
    output logic [63:0]       o_res
);
    import bn2d_pkg::*;

    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CW         = $clog2(DIV_STEPS + 1);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    t_iu_op         r_op, n_op;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [63:0]    r_q, n_q;
    logic [32:0]    r_rem, n_rem;
    logic [31:0]    r_b, n_b;
    logic [63:0]    r_r, n_r;
    logic [63:0]    r_bit, n_bit;

    logic [32:0]    rem_sh;
    logic [63:0]    rb;

    assign rem_sh = {r_rem[31:0], r_q[63]};
    assign rb     = r_r + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_b    = r_b;
        n_r    = r_r;
        n_bit  = r_bit;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_cnt  = (i_ctl.op == IU_SQRT) ? CW'(SQRT_STEPS) : CW'(DIV_STEPS);
            n_q    = i_a;
            n_rem  = '0;
            n_b    = i_b;
            n_r    = '0;
            n_bit  = 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_op == IU_SQRT) begin
                if (r_q >= rb) begin
                    n_q = r_q - rb;
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
            end else begin
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = rem_sh - {1'b0, r_b};
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q   = {r_q[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_b   <= n_b;
        r_r   <= n_r;
        r_bit <= n_bit;
    end

    assign o_res      = (r_op == IU_SQRT) ? r_r : r_q;
    assign o_sts.done = r_done;
    assign o_sts.zero = (o_res == 64'd0);

endmodule

@@ hdl/bn2d_chk.sv @@
// port-level checker for batch_norm_2d_forward_core, bound to the top level
// uses bn2d_pkg and batch_norm_2d_forward_core_macros.svh
`include "batch_norm_2d_forward_core_macros.svh"

module bn2d_chk #(
    parameter int CHANNELS = bn2d_pkg::CHANNELS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [2:0]         i_req_type,
    input logic [5:0]         i_channel,
    input logic signed [31:0] i_value,
    input logic               i_last,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_out_kind,
    input logic signed [31:0] o_out_value,
    input logic               o_out_last,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [1:0]         i_cfg_index,
    input logic [16:0]        i_cfg_data
);
    import bn2d_pkg::*;

    `BN2D_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value), "result dropped or changed while stalled")
    `BN2D_ASSERT(a_last_norm, o_out_valid && (o_out_kind != KIND_NORM) |-> !o_out_last, "last flag on a statistics result")
    `BN2D_ASSERT(a_cfg_idle, o_cfg_ready |-> o_in_ready, "configuration taken while busy")
    `BN2D_ASSERT_NEXT(a_item_busy, i_in_valid && o_in_ready && (i_req_type <= REQ_NORM) && (32'(i_channel) < 32'(CHANNELS)), !o_in_ready, "second item taken during work")
    `BN2D_ASSERT_NEXT(a_eps_sweep, i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_EPS), !o_in_ready && !o_cfg_ready, "epsilon write did not start the sweep")

endmodule

bind batch_norm_2d_forward_core bn2d_chk #(.CHANNELS(CHANNELS)) u_bn2d_chk (.*);
